FILE: sv/fir_rb_pkg.sv
// shared types and constants for the ring buffer fir filter
// used by fir_rb_cell, fir_rb_mac and fir_filter_ring_buffer; no dependencies
package fir_rb_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int FRAC_W     = 15;
	localparam int PROD_W     = 2 * SAMPLE_W;
	// sixteen full-scale products just fit
	localparam int ACC_W      = 36;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int CNT_CFG_W  = 5;
	localparam int COEFF_PER_BANK = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_TAPS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RING_LAST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BANK_A    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BANK_B    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BANK_C    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BANK_D    = 3'd5;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	// control that travels with one tap through the mac
	typedef struct packed {
		logic valid;
		logic en;
		logic last;
	} mac_ctl_t;

endpackage

FILE: sv/fir_filter_ring_buffer.sv
// fir filter over a sample ring: one sample beat in, one filtered beat out
// a new sample is refused until the previous result has moved to the output register
// the ring walk reads one ring slot per cycle and always passes through every coefficient cell
// reset: ring reads as zero, write index 0, 16 taps, ring_last 15, coefficients 0
// depends on fir_rb_pkg, fir_rb_cell and fir_rb_mac
module fir_filter_ring_buffer #(
	parameter int RING_DEPTH = 32,
	parameter int MAX_TAPS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// sample channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  fir_rb_pkg::sample_t                    sample_in,
	// result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output fir_rb_pkg::sample_t                    filtered_out,
	// configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [fir_rb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fir_rb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fir_rb_pkg::*;

	localparam int AW       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int LAST_MAX = RING_DEPTH - 1;

	// ---------------------------------------------------------------
	// configuration registers
	// ---------------------------------------------------------------
	logic [CNT_CFG_W-1:0] taps_q;
	logic [CNT_CFG_W-1:0] ring_last_q;
	logic                 cfg_wr;

	// the user must write only while idle; the block does not enforce it, and the port never pushes back
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q      <= 5'd16;
			ring_last_q <= 5'd15;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_TAPS:      taps_q      <= cfg_data[CNT_CFG_W-1:0];
				REG_RING_LAST: ring_last_q <= cfg_data[CNT_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// ring end clamped to the physical ring
	logic [AW-1:0] eff_last;
	always_comb begin
		if (9'(ring_last_q) > 9'(LAST_MAX)) begin
			eff_last = AW'(LAST_MAX);
		end else begin
			eff_last = AW'(ring_last_q);
		end
	end

	// ---------------------------------------------------------------
	// control: busy spans from the input beat to the hand-off of the result
	// ---------------------------------------------------------------
	logic          in_acc;
	logic          busy_q;
	logic          run_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] wr_idx_q;
	logic [AW-1:0] rd_ptr_q;
	logic          mac_res_valid;
	sample_t       mac_res;
	logic          res_take;

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			run_q    <= 1'b0;
			cnt_q    <= '0;
			wr_idx_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (in_acc) begin
				busy_q   <= 1'b1;
				run_q    <= 1'b1;
				cnt_q    <= '0;
				// the backward walk starts on the slot just written
				rd_ptr_q <= wr_idx_q;
				wr_idx_q <= (wr_idx_q >= eff_last) ? '0 : AW'(wr_idx_q + 1'b1);
			end else begin
				if (res_take) begin
					busy_q <= 1'b0;
				end
				if (run_q) begin
					// always walk all cells so the coefficient chain comes home
					if (cnt_q == CW'(MAX_TAPS - 1)) begin
						run_q <= 1'b0;
					end
					cnt_q    <= CW'(cnt_q + 1'b1);
					rd_ptr_q <= (rd_ptr_q == '0) ? eff_last : AW'(rd_ptr_q - 1'b1);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// sample ring: memory plus per-entry valid bits so reset reads zero
	// ---------------------------------------------------------------
	sample_t             ring_mem [RING_DEPTH];
	logic [RING_DEPTH-1:0] ring_vld_q;
	sample_t             rd_raw_s1;
	logic                rd_vld_s1;
	sample_t             sample_s1;
	mac_ctl_t            ctl_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ring_mem[wr_idx_q] <= sample_in;
		end
		rd_raw_s1 <= ring_mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
			ctl_s1     <= '0;
		end else begin
			if (in_acc) begin
				ring_vld_q[wr_idx_q] <= 1'b1;
			end
			rd_vld_s1    <= ring_vld_q[rd_ptr_q];
			ctl_s1.valid <= run_q;
			ctl_s1.en    <= run_q && (6'(cnt_q) < 6'(taps_q));
			ctl_s1.last  <= run_q && (cnt_q == CW'(MAX_TAPS - 1));
		end
	end

	// slots never written since reset read as zero
	assign sample_s1 = rd_vld_s1 ? rd_raw_s1 : '0;

	// ---------------------------------------------------------------
	// coefficient chain: cell k holds coefficient k at rest, the chain
	// rotates toward cell 0 once per tap so cell 0 feeds the mac
	// ---------------------------------------------------------------
	sample_t cell_coeff [MAX_TAPS];

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TAPS; gi++) begin : g_cell
			localparam int NB = (gi + 1) % MAX_TAPS;
			logic cell_load;

			assign cell_load = cfg_wr &&
				(cfg_index == CFG_IDX_W'(REG_BANK_A + CFG_IDX_W'(gi / COEFF_PER_BANK)));

			fir_rb_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.load     (cell_load),
				.load_val (cfg_data[SAMPLE_W*(gi % COEFF_PER_BANK) +: SAMPLE_W]),
				.shift    (ctl_s1.valid),
				.nb_coeff (cell_coeff[NB]),
				.coeff    (cell_coeff[gi])
			);
		end
	endgenerate

	// ---------------------------------------------------------------
	// multiply-accumulate, round and saturate
	// ---------------------------------------------------------------
	fir_rb_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.sample_s1 (sample_s1),
		.coeff_s1  (cell_coeff[0]),
		.res_take  (res_take),
		.res_valid (mac_res_valid),
		.res       (mac_res)
	);

	// ---------------------------------------------------------------
	// output register: a finished result moves here when the slot is free
	// ---------------------------------------------------------------
	logic    out_valid_q;
	sample_t filtered_q;

	assign res_take = mac_res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			filtered_q <= mac_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign filtered_out = filtered_q;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	// taps only reach the mac while an item is in flight
	a_tap_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s1.valid |-> busy_q)
		else $error("tap reached mac while idle");

	// a finished sum is only held while busy
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mac_res_valid |-> busy_q)
		else $error("mac result without a busy item");

	// an accepted beat starts the ring walk at tap zero
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (run_q && cnt_q == '0))
		else $error("ring walk did not start");

	// the output only turns valid from a finished sum
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(mac_res_valid))
		else $error("output valid without a result");

endmodule

FILE: sv/fir_rb_cell.sv
// one coefficient cell of the rotating coefficient chain
// depends on fir_rb_pkg
module fir_rb_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  fir_rb_pkg::sample_t load_val,
	input  logic                shift,
	input  fir_rb_pkg::sample_t nb_coeff,
	output fir_rb_pkg::sample_t coeff
);
	import fir_rb_pkg::*;

	sample_t coeff_q;

	// load from the config port, the user loading only when idle (not enforced here); rotate one place per tap when busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
		end else if (load) begin
			coeff_q <= load_val;
		end else if (shift) begin
			coeff_q <= nb_coeff;
		end
	end

	assign coeff = coeff_q;

endmodule

FILE: sv/fir_rb_mac.sv
// multiply-accumulate with rounding, saturation and a result holding register
// depends on fir_rb_pkg
module fir_rb_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fir_rb_pkg::mac_ctl_t  ctl_s1,
	input  fir_rb_pkg::sample_t   sample_s1,
	input  fir_rb_pkg::sample_t   coeff_s1,
	input  logic                  res_take,
	output logic                  res_valid,
	output fir_rb_pkg::sample_t   res
);
	import fir_rb_pkg::*;

	localparam int Q_W = ACC_W - FRAC_W;

	prod_t    prod_s2;
	mac_ctl_t ctl_s2;
	acc_t     acc_q;
	acc_t     term;
	acc_t     acc_next;
	sample_t  res_q;
	logic     res_valid_q;

	// round half up, floor shift, saturate to the sample range
	function automatic sample_t round_sat(input acc_t a);
		acc_t biased;
		logic signed [Q_W-1:0] q;
		biased = a + (acc_t'(1) <<< (FRAC_W - 1));
		q = $signed(biased[ACC_W-1:FRAC_W]);
		if (q > Q_W'(32767)) begin
			round_sat = 16'sh7fff;
		end else if (q < -Q_W'(32768)) begin
			round_sat = 16'sh8000;
		end else begin
			round_sat = sample_t'(q);
		end
	endfunction

	// product stage
	always_ff @(posedge clk) begin
		prod_s2 <= sample_s1 * coeff_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	assign term     = ctl_s2.en ? acc_t'(prod_s2) : '0;
	assign acc_next = acc_q + term;

	// accumulate, close out the sum on the last tap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (ctl_s2.valid) begin
				acc_q <= ctl_s2.last ? '0 : acc_next;
			end
			if (ctl_s2.valid && ctl_s2.last) begin
				res_valid_q <= 1'b1;
			end else if (res_take) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid && ctl_s2.last) begin
			res_q <= round_sat(acc_next);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
